// File: src/sdm_pkg.sv
// Package for the special-use domain matcher: word table, word lengths,
// group masks and the step word passed from the top level to the label tracker.
// No dependencies.
package sdm_pkg;

    localparam int WORD_COUNT = 8;
    localparam int WORD_MAX   = 9;
    localparam int LEN_W      = 4;

    localparam logic [7:0] DOT_CHAR   = 8'h2E;
    localparam logic [7:0] UPPER_LO   = 8'h41;
    localparam logic [7:0] UPPER_HI   = 8'h5A;
    localparam logic [7:0] CASE_DELTA = 8'h20;

    // Word bit order: test, example, invalid, localhost, onion, com, net, org.
    localparam int BIT_EXAMPLE = 1;
    localparam logic [WORD_COUNT-1:0] RESERVED_TLD_BITS = 8'h1F;
    localparam logic [WORD_COUNT-1:0] EXAMPLE_TLD_BITS  = 8'hE0;

    localparam logic [LEN_W-1:0] LEN_MAX = 4'd15;

    localparam logic [0:WORD_MAX-1][7:0] WORD_TEXT [WORD_COUNT] = '{
        {"test",      40'h0},
        {"example",   16'h0},
        {"invalid",   16'h0},
        {"localhost"},
        {"onion",     32'h0},
        {"com",       48'h0},
        {"net",       48'h0},
        {"org",       48'h0}
    };

    localparam logic [LEN_W-1:0] WORD_LEN [WORD_COUNT] = '{
        4'd4, 4'd7, 4'd7, 4'd9, 4'd5, 4'd3, 4'd3, 4'd3
    };

    typedef struct packed {
        logic       valid;
        logic       last;
        logic [7:0] ch;
    } sdm_step_t;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= UPPER_LO && c <= UPPER_HI)
            r = c + CASE_DELTA;
        return r;
    endfunction

    function automatic logic [7:0] word_char(input int k, input logic [LEN_W-1:0] idx);
        logic [7:0] r;
        r = 8'h00;
        if (idx < LEN_W'(WORD_MAX))
            r = WORD_TEXT[k][idx];
        return r;
    endfunction

endpackage

// File: src/special_domain_matcher_top.sv
// Top level of the special-use domain matcher: input register, label tracker
// and result register. Depends on sdm_pkg and sdm_label.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one word per name byte:
//   name_byte and final_byte, with final_byte high on the last byte of a name.
//   The output channel (out_valid/out_ready) carries one word per name,
//   is_special, produced only for the last byte; other bytes produce nothing.
//   Throughput: one byte per cycle unless a final byte waits for the result
//   register, set by the combinational label tracker update between the input
//   register and the result register. A final byte passes the input register,
//   then the result register, which loads is_special once it is free.
//   Stall: while the result register holds an untaken word, non-final bytes
//   keep flowing; a final byte waits in the input register, and in_ready
//   drops only once that register is occupied and cannot advance.
//   Reset: clears the input and result valid flags and the label state
//   (empty label, every word still a candidate, no preceding example).
module special_domain_matcher_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] name_byte,
    input  logic       final_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       is_special
);

    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       final_reg;
    logic       out_valid_reg;
    logic       special_reg;
    logic       out_free;
    logic       advance;
    logic       special;

    sdm_pkg::sdm_step_t step;

    // A byte advances unless it is final and the result slot is still full.
    assign out_free = !out_valid_reg || out_ready;
    assign advance  = in_valid_reg && (!final_reg || out_free);
    assign in_ready = !in_valid_reg || advance;

    assign step.valid = advance;
    assign step.last  = final_reg;
    assign step.ch    = byte_reg;

    sdm_label u_label (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .special (special)
    );

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    // Input payload: load on acceptance, hold otherwise.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg  <= name_byte;
            final_reg <= final_byte;
        end
    end

    // Result register: load on a final byte, drop once taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && final_reg)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && final_reg)
            special_reg <= special;
    end

    assign out_valid  = out_valid_reg;
    assign is_special = special_reg;

    a_result_from_final: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance && final_reg))
        else $error("result word without a final byte");

    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(byte_reg) && $stable(final_reg))
        else $error("stalled input word lost or changed");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !(advance && final_reg))
        else $error("result word overwritten before taken");

endmodule

// File: src/sdm_label.sv
// Label tracker: holds the per-label match state and judges the name on its
// last byte. Depends on sdm_pkg.
module sdm_label (
    input  logic              clk,
    input  logic              rst_n,
    input  sdm_pkg::sdm_step_t step,
    output logic              special
);

    logic [sdm_pkg::LEN_W-1:0]      len_reg, len_next, len_take;
    logic [sdm_pkg::WORD_COUNT-1:0] mask_reg, mask_next, mask_take, full;
    logic                           prev_reg, prev_next;
    logic [7:0]                     lc;
    logic                           is_dot;

    always_comb
    begin
        lc        = sdm_pkg::fold_case(step.ch);
        is_dot    = (step.ch == sdm_pkg::DOT_CHAR);
        mask_take = mask_reg;
        len_take  = len_reg;
        if (!is_dot)
        begin
            for (int k = 0; k < sdm_pkg::WORD_COUNT; k++)
            begin
                if (len_reg >= sdm_pkg::WORD_LEN[k] ||
                    sdm_pkg::word_char(k, len_reg) != lc)
                    mask_take[k] = 1'b0;
            end
            if (len_reg != sdm_pkg::LEN_MAX)
                len_take = len_reg + 1'b1;
        end
        for (int k = 0; k < sdm_pkg::WORD_COUNT; k++)
            full[k] = mask_take[k] && (len_take == sdm_pkg::WORD_LEN[k]);
        special = (|(full & sdm_pkg::RESERVED_TLD_BITS)) ||
                  (prev_reg && (|(full & sdm_pkg::EXAMPLE_TLD_BITS)));
    end

    // Clear after the last byte, open a new label at a dot, otherwise extend.
    always_comb
    begin
        len_next  = len_reg;
        mask_next = mask_reg;
        prev_next = prev_reg;
        if (step.valid)
        begin
            priority if (step.last)
            begin
                len_next  = '0;
                mask_next = '1;
                prev_next = 1'b0;
            end
            else if (is_dot)
            begin
                len_next  = '0;
                mask_next = '1;
                prev_next = full[sdm_pkg::BIT_EXAMPLE];
            end
            else
            begin
                len_next  = len_take;
                mask_next = mask_take;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= '0;
            mask_reg <= '1;
            prev_reg <= 1'b0;
        end
        else
        begin
            len_reg  <= len_next;
            mask_reg <= mask_next;
            prev_reg <= prev_next;
        end
    end

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        step.valid && step.last |=> len_reg == '0 && mask_reg == '1 && !prev_reg)
        else $error("label state not cleared after last byte");

    a_empty_label_full_mask: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg == '0 |-> mask_reg == '1)
        else $error("empty label with pruned candidates");

endmodule
